FILE: rtl/mfr_pkg.sv
`default_nettype none

package mfr_pkg;

    // Window geometry
    localparam int WINDOW  = 5;
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int RANK_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MED_RANK = (WINDOW - 1) / 2;

    // Field widths
    localparam int Q_W     = 23;
    localparam int LIMIT_W = 22;
    localparam int STEP_W  = 17;
    localparam int CFG_W   = LIMIT_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3272724);
    localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(32768);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_STEP  = CFG_IDX_W'(1);

    typedef logic signed [Q_W-1:0] q15_t;
    typedef q15_t win_t [WINDOW];

    localparam q15_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};

    typedef struct packed {
        logic ok;
        q15_t sample;
    } item_t;

    // Power-up window contents: -99, 99, -99, ...
    function automatic q15_t win_reset_val(input int idx);
        q15_t v;
        v = ((idx % 2) == 1) ? Q_W'(99) : -Q_W'(99);
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mfr_median.sv
`default_nettype none

module mfr_median (
    input  mfr_pkg::win_t win,
    output mfr_pkg::q15_t median
);
    import mfr_pkg::*;

    // Rank each entry against all others; ties broken by slot index so
    // every entry gets a distinct rank, then pick the middle one.
    always_comb begin
        logic [RANK_W-1:0] rank [WINDOW];
        logic less;
        median = '0;
        for (int i = 0; i < WINDOW; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW; j++) begin
                less = (j != i) &&
                       ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i)));
                rank[i] = rank[i] + RANK_W'(less);
            end
            if (rank[i] == RANK_W'(MED_RANK)) begin
                median = median | win[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mfr_state.sv
`default_nettype none

module mfr_state (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           fire,
    input  mfr_pkg::item_t                item,
    input  wire [mfr_pkg::LIMIT_W-1:0]    fault_limit,
    input  wire [mfr_pkg::STEP_W-1:0]     fault_step,
    output mfr_pkg::q15_t                 result
);
    import mfr_pkg::*;

    win_t               win_reg;
    win_t               win_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    q15_t               last_reg;

    logic               below;
    logic signed [Q_W:0] ramp_sum;
    q15_t               ramp_val;
    q15_t               push_val;
    logic               push;
    q15_t               median;

    // signed last result against unsigned limit
    assign below    = last_reg < $signed({1'b0, fault_limit});
    assign ramp_sum = {last_reg[Q_W-1], last_reg}
                    + $signed({{(Q_W+1-STEP_W){1'b0}}, fault_step});
    // step is never negative, so a sign mismatch means positive overflow
    assign ramp_val = (ramp_sum[Q_W] != ramp_sum[Q_W-1]) ? Q_MAX : ramp_sum[Q_W-1:0];

    assign push     = item.ok || below;
    assign push_val = item.ok ? item.sample : ramp_val;

    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            win_next[i] = (push && (slot_reg == SLOT_W'(i))) ? push_val : win_reg[i];
        end
        slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);
    end

    mfr_median u_median (
        .win    (win_next),
        .median (median)
    );

    assign result = push ? median : last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                win_reg[i] <= win_reset_val(i);
            end
            slot_reg <= '0;
            last_reg <= '0;
        end else if (fire) begin
            last_reg <= result;
            if (push) begin
                win_reg  <= win_next;
                slot_reg <= slot_next;
            end
        end
    end

    a_hold_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !item.ok && !below |=> last_reg == $past(last_reg))
        else $error("last result moved on a failed read at the limit");

    a_slot_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && push |=> slot_reg != $past(slot_reg) || WINDOW == 1)
        else $error("write slot did not advance on a window write");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !push |=> slot_reg == $past(slot_reg) && slot_reg <= SLOT_W'(WINDOW - 1))
        else $error("write slot changed without a window write");

    a_good_read_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.ok |=> win_reg[$past(slot_reg)] == $past(item.sample))
        else $error("good reading not stored in the window");

endmodule

`default_nettype wire

FILE: rtl/median_filter_with_fault_ramp.sv
`default_nettype none

// Channel  | Ports                 | Payload
// ---------+-----------------------+----------------------------------------
// input    | s_tvalid/s_tready     | tdata: sample_q15 [22:0]; tuser: sample_ok
// result   | m_tvalid/m_tready     | tdata: filtered_q15 [22:0]; tuser: read_failed
// config   | cfg_wr_en/cfg_index   | 0: fault_limit, 1: fault_step
//
// One request per cycle sustained while the result side does not stall; the
// result passes through the input register, then the window update and
// median into the result register. The window/last-result update and the
// rank-select median sit in the same cycle, so each item sees the one before.
// Reset (aresetn low, synchronous) empties both registers and restores the
// window to -99/99 alternating and the config registers to their defaults.
// A stalled result holds the input register; the input side stalls only when
// both the input and result registers are full.

module median_filter_with_fault_ramp (
    input  wire                               aclk,
    input  wire                               aresetn,

    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [23:0]                       s_tdata,   // [22:0] sample_q15
    input  wire                               s_tuser,   // [0] sample_ok

    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [23:0]                       m_tdata,   // [22:0] filtered_q15
    output logic                              m_tuser,   // [0] read_failed

    input  wire                               cfg_wr_en,
    input  wire  [mfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [mfr_pkg::CFG_W-1:0]         cfg_wdata
);
    import mfr_pkg::*;

    logic [LIMIT_W-1:0] fault_limit_reg;
    logic [STEP_W-1:0]  fault_step_reg;

    logic   in_valid_reg;
    item_t  in_item_reg;
    logic   out_valid_reg;
    q15_t   out_q_reg;
    logic   out_failed_reg;

    logic   proc_fire;
    q15_t   result;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_limit_reg <= LIMIT_RESET;
            fault_step_reg  <= STEP_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_FAULT_LIMIT) begin
                fault_limit_reg <= cfg_wdata[LIMIT_W-1:0];
            end else if (cfg_index == REG_FAULT_STEP) begin
                fault_step_reg <= cfg_wdata[STEP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.ok     <= s_tuser;
            in_item_reg.sample <= s_tdata[Q_W-1:0];
        end
    end

    mfr_state u_state (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (proc_fire),
        .item        (in_item_reg),
        .fault_limit (fault_limit_reg),
        .fault_step  (fault_step_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            out_q_reg      <= result;
            out_failed_reg <= !in_item_reg.ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_q_reg};
    assign m_tuser  = out_failed_reg;

    a_fire_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire |=> out_valid_reg)
        else $error("processed request did not reach the result register");

    a_in_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !proc_fire |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending input request lost");

    a_flag_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire |=> out_failed_reg == !$past(in_item_reg.ok))
        else $error("read_failed does not match the processed request");

endmodule

`default_nettype wire
